[rtl/rrss_pkg.sv]
`default_nettype none

package rrss_pkg;

   localparam int MAX_TASKS_DEF  = 8;
   localparam int COUNT_BITS_DEF = 16;

   localparam logic [7:0] RESET_SLICE = 8'd4;
   localparam logic [3:0] RESET_TOTAL = 4'd7;
   localparam logic [3:0] FIN_MAX     = 4'd15;

   typedef enum logic {
      CMD_TICK   = 1'b0,
      CMD_ARRIVE = 1'b1
   } cmd_type;

   typedef enum logic {
      REG_SLICE_LENGTH = 1'b0,
      REG_TASK_TOTAL   = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [7:0] slice_length;
      logic [3:0] task_total;
   } cfg_type;

   typedef struct packed {
      cmd_type     command;
      logic [2:0]  task_slot;
      logic [15:0] burst_length;
   } req_type;

   typedef struct packed {
      logic        running_valid;
      logic [2:0]  running_slot;
      logic        finished_valid;
      logic [15:0] finished_wait;
      logic [15:0] finished_turnaround;
      logic        all_done;
      logic        arrive_error;
      logic [15:0] time_now;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/rrss_csr.sv]
`default_nettype none

module rrss_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output rrss_pkg::cfg_type cfg
);
   import rrss_pkg::*;

   logic [7:0]    slice_ff;
   logic [7:0]    slice_in;
   logic [3:0]    total_ff;
   logic [3:0]    total_in;
   logic          wr_en;
   reg_index_type reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = reg_index_type'(csr_paddr[2]);

   always_comb begin
      slice_in   = slice_ff;
      total_in   = total_ff;
      csr_prdata = '0;
      case (reg_sel)
         REG_SLICE_LENGTH: begin
            csr_prdata = {24'd0, slice_ff};
            if (wr_en) slice_in = csr_pwdata[7:0];
         end
         REG_TASK_TOTAL: begin
            csr_prdata = {28'd0, total_ff};
            if (wr_en) total_in = csr_pwdata[3:0];
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slice_ff <= RESET_SLICE;
         total_ff <= RESET_TOTAL;
      end else begin
         slice_ff <= slice_in;
         total_ff <= total_in;
      end
   end

   assign cfg.slice_length = slice_ff;
   assign cfg.task_total   = total_ff;

endmodule

`default_nettype wire

[rtl/rrss_pick.sv]
`default_nettype none

module rrss_pick #(
   parameter int MAX_TASKS = rrss_pkg::MAX_TASKS_DEF
) (
   input  logic [MAX_TASKS-1:0]             unf_pos,
   input  logic [$clog2(MAX_TASKS)-1:0]     act_pos,
   input  logic [$clog2(MAX_TASKS+1)-1:0]   cnt,
   output logic                             found,
   output logic [$clog2(MAX_TASKS)-1:0]     pick_pos
);
   import rrss_pkg::*;

   localparam int SLOT_W = $clog2(MAX_TASKS);
   localparam int PW     = $clog2(MAX_TASKS + 1) + 1;

   logic [PW-1:0] sum;

   // rotating search: first unfinished position after the active one,
   // the active position itself last
   always_comb begin
      found    = 1'b0;
      pick_pos = act_pos;
      sum      = '0;
      for (int i = MAX_TASKS; i >= 1; i--) begin
         sum = PW'(act_pos) + PW'(i);
         if (sum >= PW'(cnt)) sum = sum - PW'(cnt);
         if ((PW'(i) <= PW'(cnt)) && unf_pos[sum[SLOT_W-1:0]]) begin
            found    = 1'b1;
            pick_pos = sum[SLOT_W-1:0];
         end
      end
   end

endmodule

`default_nettype wire

[rtl/rrss_core.sv]
`default_nettype none

module rrss_core #(
   parameter int MAX_TASKS  = rrss_pkg::MAX_TASKS_DEF,
   parameter int COUNT_BITS = rrss_pkg::COUNT_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  rrss_pkg::req_type req,
   input  rrss_pkg::cfg_type cfg,
   output rrss_pkg::rsp_type rsp
);
   import rrss_pkg::*;

   localparam int SLOT_W = $clog2(MAX_TASKS);
   localparam int CNT_W  = $clog2(MAX_TASKS + 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [32:0] COUNT_MAX_W = 33'(COUNT_MAX);

   // per-slot lanes
   logic [COUNT_BITS-1:0] rem_ff  [MAX_TASKS];
   logic [COUNT_BITS-1:0] rem_in  [MAX_TASKS];
   logic [COUNT_BITS-1:0] wait_ff [MAX_TASKS];
   logic [COUNT_BITS-1:0] wait_in [MAX_TASKS];
   logic [COUNT_BITS-1:0] turn_ff [MAX_TASKS];
   logic [COUNT_BITS-1:0] turn_in [MAX_TASKS];
   logic [SLOT_W-1:0]     order_ff [MAX_TASKS];
   logic [SLOT_W-1:0]     order_in [MAX_TASKS];
   logic [MAX_TASKS-1:0]  enrolled_ff;
   logic [MAX_TASKS-1:0]  enrolled_in;

   logic [CNT_W-1:0]      cnt_ff;
   logic [CNT_W-1:0]      cnt_in;
   logic [SLOT_W-1:0]     act_pos_ff;
   logic [SLOT_W-1:0]     act_pos_in;
   logic                  act_valid_ff;
   logic                  act_valid_in;
   logic [7:0]            slice_ff;
   logic [7:0]            slice_in;
   logic [3:0]            fin_cnt_ff;
   logic [3:0]            fin_cnt_in;
   logic [COUNT_BITS-1:0] time_ff;
   logic [COUNT_BITS-1:0] time_in;

   logic [MAX_TASKS-1:0]  is_act;
   logic [MAX_TASKS-1:0]  live;
   logic [MAX_TASKS-1:0]  unf_slot;
   logic [MAX_TASKS-1:0]  unf_pos;
   logic [SLOT_W-1:0]     act_slot;
   logic                  act_ok;
   logic                  run;
   logic                  act_last;
   logic [COUNT_BITS-1:0] act_wait;
   logic [COUNT_BITS-1:0] act_turn;
   logic [7:0]            slice_next;
   logic                  found;
   logic [SLOT_W-1:0]     pick_pos;
   logic [32:0]           slot_wide;
   logic [SLOT_W-1:0]     slot_idx;
   logic                  slot_ok;
   logic                  slot_taken;
   logic [32:0]           burst_wide;
   logic                  err;
   logic [32:0]           run_slot_wide;
   logic [32:0]           wait_wide;
   logic [32:0]           turn_wide;
   logic [32:0]           time_wide;

   always_comb begin
      act_ok   = act_valid_ff && (33'(act_pos_ff) < 33'(cnt_ff));
      act_slot = order_ff[act_pos_ff];
      for (int i = 0; i < MAX_TASKS; i++) begin
         is_act[i] = act_ok && (act_slot == SLOT_W'(i));
         live[i]   = enrolled_ff[i] && (rem_ff[i] != '0);
      end
      run = |(is_act & live);
   end

   always_comb begin
      rem_in       = rem_ff;
      wait_in      = wait_ff;
      turn_in      = turn_ff;
      order_in     = order_ff;
      enrolled_in  = enrolled_ff;
      cnt_in       = cnt_ff;
      act_pos_in   = act_pos_ff;
      act_valid_in = act_valid_ff;
      slice_in     = slice_ff;
      fin_cnt_in   = fin_cnt_ff;
      time_in      = time_ff;
      act_last     = 1'b0;
      act_wait     = '0;
      act_turn     = '0;
      slice_next   = slice_ff + 8'd1;
      slot_wide    = 33'(req.task_slot);
      slot_idx     = slot_wide[SLOT_W-1:0];
      slot_ok      = slot_wide < 33'(MAX_TASKS);
      slot_taken   = slot_ok && enrolled_ff[slot_idx];
      burst_wide   = 33'(req.burst_length);
      err          = 1'b0;
      rsp          = '0;

      if (req.command == CMD_ARRIVE) begin
         err = !slot_ok || (req.burst_length == 16'd0) ||
               (33'(cnt_ff) >= 33'(MAX_TASKS)) || slot_taken;
         if (!err) begin
            rem_in[slot_idx]  = (burst_wide > COUNT_MAX_W) ? COUNT_MAX
                                                          : burst_wide[COUNT_BITS-1:0];
            wait_in[slot_idx] = '0;
            turn_in[slot_idx] = '0;
            enrolled_in[slot_idx] = 1'b1;
            order_in[cnt_ff[SLOT_W-1:0]] = slot_idx;
            if (!act_valid_ff) begin
               act_valid_in = 1'b1;
               act_pos_in   = cnt_ff[SLOT_W-1:0];
               slice_in     = 8'd0;
            end
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end else begin
         for (int i = 0; i < MAX_TASKS; i++) begin
            if (live[i]) begin
               if (!is_act[i]) begin
                  wait_in[i] = (wait_ff[i] == COUNT_MAX) ? wait_ff[i]
                                                         : wait_ff[i] + COUNT_BITS'(1);
               end
               turn_in[i] = (turn_ff[i] == COUNT_MAX) ? turn_ff[i]
                                                      : turn_ff[i] + COUNT_BITS'(1);
            end
            if (run && is_act[i]) begin
               rem_in[i] = rem_ff[i] - COUNT_BITS'(1);
               act_last  = (rem_ff[i] == COUNT_BITS'(1));
               act_wait  = wait_in[i];
               act_turn  = turn_in[i];
            end
         end
         time_in = (time_ff == COUNT_MAX) ? time_ff : time_ff + COUNT_BITS'(1);
         if (run) begin
            if (act_last && (fin_cnt_ff != FIN_MAX)) fin_cnt_in = fin_cnt_ff + 4'd1;
            if (act_last || (slice_next >= cfg.slice_length)) begin
               slice_in = 8'd0;
               if (found) act_pos_in   = pick_pos;
               else       act_valid_in = 1'b0;
            end else begin
               slice_in = slice_next;
            end
         end else begin
            act_valid_in = 1'b0;
         end
      end

      run_slot_wide           = 33'(act_slot);
      wait_wide               = 33'(act_wait);
      turn_wide               = 33'(act_turn);
      time_wide               = 33'(time_in);
      rsp.running_valid       = (req.command == CMD_TICK) && run;
      rsp.running_slot        = rsp.running_valid ? run_slot_wide[2:0] : 3'd0;
      rsp.finished_valid      = rsp.running_valid && act_last;
      rsp.finished_wait       = rsp.finished_valid ? wait_wide[15:0] : 16'd0;
      rsp.finished_turnaround = rsp.finished_valid ? turn_wide[15:0] : 16'd0;
      rsp.all_done            = (fin_cnt_in >= cfg.task_total);
      rsp.arrive_error        = err;
      rsp.time_now            = time_wide[15:0];
   end

   // unfinished flags after this tick's decrement, laid out in arrival order
   always_comb begin
      for (int i = 0; i < MAX_TASKS; i++) begin
         unf_slot[i] = enrolled_ff[i] && (rem_in[i] != '0);
      end
      for (int p = 0; p < MAX_TASKS; p++) begin
         unf_pos[p] = (33'(p) < 33'(cnt_ff)) && unf_slot[order_ff[p]];
      end
   end

   rrss_pick #(
      .MAX_TASKS (MAX_TASKS)
   ) u_pick (
      .unf_pos  (unf_pos),
      .act_pos  (act_pos_ff),
      .cnt      (cnt_ff),
      .found    (found),
      .pick_pos (pick_pos)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         enrolled_ff  <= '0;
         cnt_ff       <= '0;
         act_pos_ff   <= '0;
         act_valid_ff <= 1'b0;
         slice_ff     <= 8'd0;
         fin_cnt_ff   <= 4'd0;
         time_ff      <= '0;
      end else if (fire) begin
         enrolled_ff  <= enrolled_in;
         cnt_ff       <= cnt_in;
         act_pos_ff   <= act_pos_in;
         act_valid_ff <= act_valid_in;
         slice_ff     <= slice_in;
         fin_cnt_ff   <= fin_cnt_in;
         time_ff      <= time_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rem_ff   <= rem_in;
         wait_ff  <= wait_in;
         turn_ff  <= turn_in;
         order_ff <= order_in;
      end
   end

`ifndef SYNTH
   a_active_in_range: assert property (@(posedge clock) disable iff (reset)
      act_valid_ff |-> (33'(act_pos_ff) < 33'(cnt_ff)))
      else $error("active position beyond order list");

   a_enrol_count: assert property (@(posedge clock) disable iff (reset)
      $countones(enrolled_ff) == int'(cnt_ff))
      else $error("enrolled count out of step with enrolled slots");

   a_arrive_starts: assert property (@(posedge clock) disable iff (reset)
      (fire && (req.command == CMD_ARRIVE) && !rsp.arrive_error) |=> act_valid_ff)
      else $error("accepted arrival left scheduler idle");

   a_finish_runs: assert property (@(posedge clock) disable iff (reset)
      (fire && rsp.finished_valid) |=> !enrolled_ff[$past(act_slot)] ||
         (rem_ff[$past(act_slot)] == '0))
      else $error("finished task still has work");
`endif

endmodule

`default_nettype wire

[rtl/round_robin_slice_scheduler.sv]
`default_nettype none

// channel   ports      direction  payload
// request   req_*      in         tuser: command; tdata: task_slot, burst_length
// result    rsp_*      out        tuser: flags; tdata: slot, counts, time
// config    csr_*      in/out     slice_length @ 0x0, task_total @ 0x4
//
// one request per cycle sustained while rsp_tready is held high; a request passes the input register,
// one pass of slot-lane update and rotating pick, and the result register
// reset: synchronous, clears scheduler control, enrolment and config registers
// req_tready drops only while both input and result registers are full and rsp_tready is low
// the user must write configuration only while the block is idle; the block does not enforce this

module round_robin_slice_scheduler #(
   parameter int MAX_TASKS  = rrss_pkg::MAX_TASKS_DEF,
   parameter int COUNT_BITS = rrss_pkg::COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // task_slot[2:0], burst_length[18:3], zero fill
   input  logic        req_tuser,   // command[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // running_slot[2:0], finished_wait[18:3], finished_turnaround[34:19],
   // all_done[35], time_now[51:36], zero fill
   output logic [55:0] rsp_tdata,
   // running_valid[0], finished_valid[1], arrive_error[2]
   output logic [2:0]  rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import rrss_pkg::*;

   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_req_ff;
   req_type in_req_in;
   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type out_rsp_ff;
   rsp_type out_rsp_in;
   rsp_type core_rsp;
   cfg_type cfg;
   logic    advance;
   logic    req_take;

   rrss_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_req_in = in_req_ff;
      if (req_take) begin
         in_req_in.command      = cmd_type'(req_tuser);
         in_req_in.task_slot    = req_tdata[2:0];
         in_req_in.burst_length = req_tdata[18:3];
      end
      in_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
      out_rsp_in   = advance ? core_rsp : out_rsp_ff;
   end

   rrss_core #(
      .MAX_TASKS  (MAX_TASKS),
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .req   (in_req_ff),
      .cfg   (cfg),
      .rsp   (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_req_ff  <= in_req_in;
      out_rsp_ff <= out_rsp_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_rsp_ff.time_now, out_rsp_ff.all_done,
                        out_rsp_ff.finished_turnaround, out_rsp_ff.finished_wait,
                        out_rsp_ff.running_slot};
   assign rsp_tuser  = {out_rsp_ff.arrive_error, out_rsp_ff.finished_valid,
                        out_rsp_ff.running_valid};

endmodule

`default_nettype wire

[sim/round_robin_slice_scheduler_test.sv]
`timescale 1ns / 100ps

module round_robin_slice_scheduler_test;
   import rrss_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   class slice_scoreboard;
      logic [15:0] work_left  [MAX_TASKS_DEF];
      logic [15:0] waited     [MAX_TASKS_DEF];
      logic [15:0] turnaround [MAX_TASKS_DEF];
      bit          enrolled   [MAX_TASKS_DEF];
      logic [2:0]  order      [MAX_TASKS_DEF];
      int unsigned n_enrolled;
      int unsigned active_pos;
      bit          running;
      logic [7:0]  slice_used;
      logic [3:0]  n_finished;
      logic [15:0] tick_count;
      logic [7:0]  quantum;
      logic [3:0]  done_target;
      rsp_type     predicted[$];
      int unsigned checked;
      int unsigned failures;

      function new();
         for (int i = 0; i < MAX_TASKS_DEF; i++) begin
            work_left[i] = '0;
            waited[i] = '0;
            turnaround[i] = '0;
            enrolled[i] = 1'b0;
            order[i] = '0;
         end
         n_enrolled = 0;
         active_pos = 0;
         running = 1'b0;
         slice_used = '0;
         n_finished = '0;
         tick_count = '0;
         quantum = RESET_SLICE;
         done_target = RESET_TOTAL;
         checked = 0;
         failures = 0;
      endfunction

      function logic [15:0] bump(logic [15:0] v);
         return (v == COUNT_MAX) ? v : v + 16'd1;
      endfunction

      function void note_request(req_type r);
         rsp_type     out;
         int unsigned act;
         int unsigned i;
         int unsigned p;
         bit          has_act;
         bit          done;
         bit          found;
         out = '0;
         if (r.command == CMD_ARRIVE) begin
            if (r.burst_length == 16'd0 || n_enrolled >= MAX_TASKS_DEF
                || enrolled[r.task_slot]) begin
               out.arrive_error = 1'b1;
            end else begin
               work_left[r.task_slot] = r.burst_length;
               waited[r.task_slot] = '0;
               turnaround[r.task_slot] = '0;
               enrolled[r.task_slot] = 1'b1;
               order[n_enrolled] = r.task_slot;
               // an idle scheduler starts the newcomer right away
               if (!running) begin
                  running = 1'b1;
                  active_pos = n_enrolled;
                  slice_used = '0;
               end
               n_enrolled++;
            end
         end else begin
            has_act = running && active_pos < n_enrolled;
            act = 0;
            if (has_act)
               act = order[active_pos];
            else
               running = 1'b0;
            for (i = 0; i < MAX_TASKS_DEF; i++) begin
               if (enrolled[i] && work_left[i] != 16'd0) begin
                  if (!has_act || i != act)
                     waited[i] = bump(waited[i]);
                  turnaround[i] = bump(turnaround[i]);
               end
            end
            tick_count = bump(tick_count);
            if (running && work_left[act] != 16'd0) begin
               out.running_valid = 1'b1;
               out.running_slot = act[2:0];
               work_left[act] = work_left[act] - 16'd1;
               slice_used = slice_used + 8'd1;
               done = (work_left[act] == 16'd0);
               if (done) begin
                  out.finished_valid = 1'b1;
                  out.finished_wait = waited[act];
                  out.finished_turnaround = turnaround[act];
                  if (n_finished != FIN_MAX)
                     n_finished++;
               end
               // a zero quantum compares like one
               if (done || slice_used >= quantum) begin
                  slice_used = '0;
                  found = 1'b0;
                  for (i = 1; i <= n_enrolled && !found; i++) begin
                     p = (active_pos + i) % n_enrolled;
                     if (work_left[order[p]] != 16'd0) begin
                        found = 1'b1;
                        active_pos = p;
                     end
                  end
                  if (!found)
                     running = 1'b0;
               end
            end else begin
               running = 1'b0;
            end
         end
         out.all_done = (n_finished >= done_target);
         out.time_now = tick_count;
         predicted.push_back(out);
      endfunction

      task report(string what);
         failures++;
         if (failures <= 30)
            $display("mismatch at %0t ns: %s", $time, what);
      endtask

      task compare_field(string name, logic [15:0] got, logic [15:0] want);
         if (got !== want)
            report($sformatf("result %0d %s got %0h expected %0h", checked, name, got, want));
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (predicted.size() == 0) begin
            report($sformatf("result with no request pending: %p", got));
            return;
         end
         want = predicted.pop_front();
         compare_field("running_valid", got.running_valid, want.running_valid);
         compare_field("running_slot", got.running_slot, want.running_slot);
         compare_field("finished_valid", got.finished_valid, want.finished_valid);
         compare_field("finished_wait", got.finished_wait, want.finished_wait);
         compare_field("finished_turnaround", got.finished_turnaround,
                       want.finished_turnaround);
         compare_field("all_done", got.all_done, want.all_done);
         compare_field("arrive_error", got.arrive_error, want.arrive_error);
         compare_field("time_now", got.time_now, want.time_now);
         checked++;
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   slice_scoreboard sb = new();
   bit gaps_on = 1'b1;
   bit stalls_on = 1'b1;
   int quiet_cycles = 0;

   round_robin_slice_scheduler uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // result side back-pressure in bursts
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stalls_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.running_valid = rsp_tuser[0];
         got.finished_valid = rsp_tuser[1];
         got.arrive_error = rsp_tuser[2];
         got.running_slot = rsp_tdata[2:0];
         got.finished_wait = rsp_tdata[18:3];
         got.finished_turnaround = rsp_tdata[34:19];
         got.all_done = rsp_tdata[35];
         got.time_now = rsp_tdata[51:36];
         sb.check_result(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic send_request(cmd_type cmd, logic [2:0] slot, logic [15:0] burst);
      req_type r;
      r.command = cmd;
      r.task_slot = slot;
      r.burst_length = burst;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'd0, burst, slot};
      req_tuser <= cmd;
      do @(posedge clock); while (!req_tready);
      sb.note_request(r);
   endtask

   task automatic send_ticks(int count);
      repeat (count) send_request(CMD_TICK, 3'($urandom), 16'($urandom));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.predicted.size() != 0) @(posedge clock);
   endtask

   task automatic read_register(reg_index_type idx);
      logic [31:0] want;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      want = (idx == REG_SLICE_LENGTH) ? {24'd0, sb.quantum} : {28'd0, sb.done_target};
      if (csr_prdata !== want)
         sb.report($sformatf("register %s read %0h expected %0h", idx.name(), csr_prdata,
                             want));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_register(reg_index_type idx, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == REG_SLICE_LENGTH)
         sb.quantum = value[7:0];
      else
         sb.done_target = value[3:0];
      read_register(idx);
   endtask

   task automatic random_phase(int count, int enrol_cap);
      cmd_type     cmd;
      logic [2:0]  slot;
      logic [15:0] burst;
      repeat (count) begin
         slot = 3'($urandom_range(0, 7));
         burst = 16'($urandom);
         cmd = CMD_TICK;
         if ($urandom_range(0, 4) == 0) begin
            cmd = CMD_ARRIVE;
            // enrolled slots take any burst and are turned away
            if (!sb.enrolled[slot]) begin
               if (sb.n_enrolled < enrol_cap && $urandom_range(0, 7) != 0)
                  burst = 16'($urandom_range(1, 64));
               else
                  burst = 16'd0;
            end
         end
         send_request(cmd, slot, burst);
      end
   endtask

   initial begin
      int          soak_n;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= 1'b0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      read_register(REG_SLICE_LENGTH);
      read_register(REG_TASK_TOTAL);

      // idle tick, zero burst, start on arrival, duplicate slot
      send_ticks(1);
      send_request(CMD_ARRIVE, 3'd3, 16'd0);
      send_request(CMD_ARRIVE, 3'd6, 16'd9);
      send_request(CMD_ARRIVE, 3'd6, 16'd5);
      send_ticks(1);
      send_request(CMD_ARRIVE, 3'd1, 16'd2);
      // preemption, finish, wrap past the finished task, lone task, then idle
      send_ticks(11);
      send_request(CMD_ARRIVE, 3'd1, 16'hFFFF);
      send_ticks(2);
      drain();

      write_register(REG_SLICE_LENGTH, ($urandom & 32'hFFFF_FF00) | 32'd1);
      write_register(REG_TASK_TOTAL, ($urandom & 32'hFFFF_FFF0) | 32'd1);
      random_phase(100, 3);
      drain();

      write_register(REG_SLICE_LENGTH, $urandom & 32'hFFFF_FF00);
      write_register(REG_TASK_TOTAL, $urandom & 32'hFFFF_FFF0);
      random_phase(100, 4);
      drain();

      write_register(REG_SLICE_LENGTH, $urandom_range(2, 7));
      write_register(REG_TASK_TOTAL, 32'd15);
      random_phase(100, 5);
      drain();

      write_register(REG_SLICE_LENGTH, $urandom_range(2, 12));
      write_register(REG_TASK_TOTAL, $urandom_range(1, 8));
      random_phase(100, 5);
      drain();

      // closing run without idling: fill every slot, then tick back to back
      gaps_on = 1'b0;
      stalls_on = 1'b0;
      write_register(REG_SLICE_LENGTH, 32'hFFFF_FFFF);
      write_register(REG_TASK_TOTAL, 32'd8);
      soak_n = 0;
      for (int s = 0; s < MAX_TASKS_DEF; s++) begin
         if (!sb.enrolled[s]) begin
            send_request(CMD_ARRIVE, s[2:0], (soak_n < 2) ? 16'hFFFF : 16'd1000);
            soak_n++;
         end
      end
      send_ticks(24);
      // order list full
      for (int s = 0; s < MAX_TASKS_DEF; s++)
         send_request(CMD_ARRIVE, s[2:0], 16'($urandom));
      send_ticks(3);
      drain();
      repeat (8) @(posedge clock);

      if (sb.failures == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
